// File: rtl/teq_pkg.sv
package teq_pkg;

	// op codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// one stored event
	typedef struct packed {
		logic [15:0] ev_time;
		logic [15:0] vertex;
		logic        kind;
	} entry_t;

	// broadcast from the top level to every cell for one beat
	typedef struct packed {
		logic   push_en;  // accepted push into a queue that is not full
		logic   pop_en;   // accepted pop from a queue that is not empty
		logic   head_gt;  // head time is greater than the new time
		entry_t new_ent;  // event carried by the push
	} cell_ctrl_t;

endpackage

// File: rtl/teq_cell.sv
module teq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  teq_pkg::cell_ctrl_t ctrl,
	input  logic                cmp_en,      // low in the head cell
	input  logic                left_valid,
	input  logic                left_shift,
	input  teq_pkg::entry_t     left_ent,
	input  logic                right_valid,
	input  teq_pkg::entry_t     right_ent,
	output logic                valid,
	output logic                shift,
	output teq_pkg::entry_t     ent
);

	logic            valid_q;
	teq_pkg::entry_t ent_q;
	logic            ge;
	logic            take_new;

	// compare own time with the new time, decide whether to move right
	assign ge       = ent_q.ev_time >= ctrl.new_ent.ev_time;
	assign shift    = valid_q && (ctrl.head_gt || (cmp_en && ge));
	assign take_new = !left_shift && left_valid && (!valid_q || shift);

	// advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop_en) begin
			valid_q <= right_valid;
		end else if (ctrl.push_en && (left_shift || take_new)) begin
			valid_q <= 1'b1;
		end
	end

	// advance the payload: pull from the right on pop, from the left or the bus on push
	always_ff @(posedge clk) begin
		if (ctrl.pop_en) begin
			ent_q <= right_ent;
		end else if (ctrl.push_en) begin
			if (left_shift) begin
				ent_q <= left_ent;
			end else if (take_new) begin
				ent_q <= ctrl.new_ent;
			end
		end
	end

	assign valid = valid_q;
	assign ent   = ent_q;

endmodule

// File: rtl/time_ordered_event_queue.sv
// Channel  | Ports                                              | Dir | Handshake
// ---------+----------------------------------------------------+-----+--------------------
// command  | op, event_time, vertex_id, event_kind              | in  | start high, busy low
// result   | popped_valid, popped_time, popped_vertex,          | out | done high, one cycle
//          | popped_kind, was_empty, push_dropped, occupancy    |     |
//
// One beat per cycle: a row of QUEUE_DEPTH cells compares the new time in
// parallel and shifts its entries, so busy stays low and a command may
// follow in every cycle. The result of a command shows on the cycle after
// it is taken, with done high for exactly that cycle. The receiver cannot
// stall. Reset empties the queue at once; entry payloads are not cleared.
module time_ordered_event_queue #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [15:0] event_time,
	input  logic [15:0] vertex_id,
	input  logic        event_kind,
	output logic        done,
	output logic        popped_valid,
	output logic [15:0] popped_time,
	output logic [15:0] popped_vertex,
	output logic        popped_kind,
	output logic        was_empty,
	output logic        push_dropped,
	output logic [6:0]  occupancy
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W+6:0]    count_ext;
	logic                full;
	logic                empty;
	logic                push_req;
	logic                pop_req;
	teq_pkg::cell_ctrl_t ctrl;

	logic [QUEUE_DEPTH-1:0] vld;
	logic [QUEUE_DEPTH-1:0] shf;
	teq_pkg::entry_t        ent [QUEUE_DEPTH];

	logic        done_q;
	logic        pv_q;
	logic [15:0] pt_q;
	logic [15:0] pvx_q;
	logic        pk_q;
	logic        empty_q;
	logic        drop_q;

	assign busy     = 1'b0;
	assign full     = count_q == FULL_CNT;
	assign empty    = count_q == '0;
	assign push_req = start && (op == teq_pkg::OP_PUSH);
	assign pop_req  = start && (op == teq_pkg::OP_POP);

	// broadcast the command to the row
	always_comb begin
		ctrl.push_en         = push_req && !full;
		ctrl.pop_en          = pop_req && !empty;
		ctrl.new_ent.ev_time = event_time;
		ctrl.new_ent.vertex  = vertex_id;
		ctrl.new_ent.kind    = event_kind;
		ctrl.head_gt         = vld[0] && (ent[0].ev_time > event_time);
	end

	// build the row of cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic            lv;
		logic            ls;
		teq_pkg::entry_t le;
		logic            rv;
		teq_pkg::entry_t re;

		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign ls = 1'b0;
			assign le = ctrl.new_ent;
		end else begin : g_body
			assign lv = vld[i-1];
			assign ls = shf[i-1];
			assign le = ent[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign re = ent[i];
		end else begin : g_mid
			assign rv = vld[i+1];
			assign re = ent[i+1];
		end

		teq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.cmp_en      (i != 0),
			.left_valid  (lv),
			.left_shift  (ls),
			.left_ent    (le),
			.right_valid (rv),
			.right_ent   (re),
			.valid       (vld[i]),
			.shift       (shf[i]),
			.ent         (ent[i])
		);
	end

	// track the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push_en) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop_en) begin
			count_q <= count_q - 1'b1;
		end
	end

	// strobe one result for each taken command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// hold the result payload
	always_ff @(posedge clk) begin
		if (start) begin
			pv_q    <= ctrl.pop_en;
			pt_q    <= ctrl.pop_en ? ent[0].ev_time : 16'd0;
			pvx_q   <= ctrl.pop_en ? ent[0].vertex : 16'd0;
			pk_q    <= ctrl.pop_en ? ent[0].kind : 1'b0;
			empty_q <= pop_req && empty;
			drop_q  <= push_req && full;
		end
	end

	assign count_ext     = {7'd0, count_q};
	assign done          = done_q;
	assign popped_valid  = pv_q;
	assign popped_time   = pt_q;
	assign popped_vertex = pvx_q;
	assign popped_kind   = pk_q;
	assign was_empty     = empty_q;
	assign push_dropped  = drop_q;
	assign occupancy     = count_ext[6:0];

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("fill count beyond depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld) == 32'(count_q))
		else $error("valid bits disagree with fill count");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] == !empty)
		else $error("head valid bit disagrees with fill count");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		vld[1] |-> ent[0].ev_time <= ent[1].ev_time)
		else $error("head is later than second entry");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_req && full |=> done && push_dropped && $stable(count_q))
		else $error("push into full queue changed state");

endmodule
